// ===== design/nsse_pkg.sv =====
// Shared types and constants for the nibble span sprite expander.
package nsse_pkg;

    localparam logic [31:0] SIGNATURE_WORD  = 32'h006d6647;
    localparam logic [31:0] TERMINATOR_WORD = 32'h2a2a2a2a;
    localparam logic [3:0]  HEADER_LAST     = 4'd15;

    // Command queue between the parser and the word generator.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        OP_HEADER,
        OP_BYTE,
        OP_PIXEL,
        OP_PALETTE
    } cmd_op_t;

    // One parsed command. Header: word_a is the object size, word_b width and height.
    // Byte: word_a is the byte as a word. Palette: word_a is the colour, idx_a the slot.
    // Pixel: idx_a then idx_b (when two is set), with their range flags.
    typedef struct packed {
        cmd_op_t     op;
        logic        term;
        logic        wr;
        logic        two;
        logic        ok_a;
        logic        ok_b;
        logic [7:0]  idx_a;
        logic [7:0]  idx_b;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } cmd_t;

endpackage

// ===== design/nsse_if.sv =====
// Valid/ready channel interfaces for the input bytes and the output words.
interface nsse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

interface nsse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        last_word;
    logic        bad_index;

    modport source (output valid, output out_word, output last_word, output bad_index,
                    input ready);
    modport sink (input valid, input out_word, input last_word, input bad_index,
                  output ready);
endinterface

// ===== design/nsse_front.sv =====
// Byte parser: walks the header, palette and span structure and issues commands.
module nsse_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    nsse_in_if.sink        in_ch,
    input  logic           fifo_full,
    output logic           cmd_push,
    output nsse_pkg::cmd_t cmd
);
    import nsse_pkg::*;

    localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_LINE,
        PH_JUMP,
        PH_SIZE,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [9:0]  cnt_reg, cnt_next, cnt_cur, cnt_inc;
    logic [7:0]  cc_reg, cc_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] asm_reg, asm_next;
    logic [15:0] lines_reg, lines_next, lines_dec;
    logic [7:0]  spans_reg, spans_next;
    logic [7:0]  pixels_reg, pixels_next;
    logic [7:0]  slot;
    logic [3:0]  k;
    logic [7:0]  b;
    logic        accept;
    logic        push_c;
    logic        two;

    assign in_ch.ready = !fifo_full;
    assign accept      = in_ch.valid && !fifo_full;
    assign cmd_push    = accept && push_c;
    assign b           = in_ch.in_byte;

    always_comb
    begin
        phase_cur   = in_ch.first_byte ? PH_HEADER : phase_reg;
        cnt_cur     = in_ch.first_byte ? 10'd0 : cnt_reg;
        k           = cnt_cur[3:0];
        cnt_inc     = cnt_cur + 10'd1;
        slot        = cnt_inc[9:2] - 8'd1;
        lines_dec   = lines_reg - 16'd1;
        two         = (pixels_reg >= 8'd2);
        phase_next  = phase_cur;
        cnt_next    = cnt_cur;
        cc_next     = cc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        size_next   = size_reg;
        asm_next    = asm_reg;
        lines_next  = lines_reg;
        spans_next  = spans_reg;
        pixels_next = pixels_reg;
        push_c      = 1'b0;
        cmd         = '0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                case (k)
                    4'd3:  cc_next            = b;
                    4'd8:  width_next[7:0]    = b;
                    4'd9:  width_next[15:8]   = b;
                    4'd10: height_next[7:0]   = b;
                    4'd11: height_next[15:8]  = b;
                    4'd12: size_next[7:0]     = b;
                    4'd13: size_next[15:8]    = b;
                    4'd14: size_next[23:16]   = b;
                    4'd15: size_next[31:24]   = b;
                    default: ;
                endcase
                if (k == HEADER_LAST)
                begin
                    push_c      = 1'b1;
                    cmd.op      = OP_HEADER;
                    cmd.word_a  = size_next;
                    cmd.word_b  = {width_reg, height_reg};
                    cnt_next    = 10'd0;
                    lines_next  = height_reg;
                    if (cc_reg != 8'd0)
                        phase_next = PH_PALETTE;
                    else if (height_reg == 16'd0)
                    begin
                        cmd.term   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LINE;
                end
                else
                    cnt_next = cnt_inc;
            end
            PH_PALETTE:
            begin
                asm_next   = {b, asm_reg[31:8]};
                cmd.op     = OP_PALETTE;
                cmd.word_a = asm_next;
                cmd.idx_a  = slot;
                cmd.wr     = (cnt_inc[1:0] == 2'd0) && ({1'b0, slot} < DEPTH_W);
                if (cnt_inc >= {cc_reg, 2'b00})
                begin
                    cnt_next = 10'd0;
                    if (lines_reg == 16'd0)
                    begin
                        cmd.term   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LINE;
                end
                else
                    cnt_next = cnt_inc;
                push_c = cmd.wr || cmd.term;
            end
            PH_LINE:
            begin
                push_c     = 1'b1;
                cmd.op     = OP_BYTE;
                cmd.word_a = {24'd0, b};
                lines_next = lines_dec;
                spans_next = b;
                if (b != 8'd0)
                    phase_next = PH_JUMP;
                else if (lines_dec == 16'd0)
                begin
                    cmd.term   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_LINE;
            end
            PH_JUMP:
            begin
                push_c     = 1'b1;
                cmd.op     = OP_BYTE;
                cmd.word_a = {24'd0, b};
                spans_next = spans_reg - 8'd1;
                phase_next = PH_SIZE;
            end
            PH_SIZE:
            begin
                push_c      = 1'b1;
                cmd.op      = OP_BYTE;
                cmd.word_a  = {24'd0, b};
                pixels_next = b;
                if (b != 8'd0)
                    phase_next = PH_PIXEL;
                else if (spans_reg != 8'd0)
                    phase_next = PH_JUMP;
                else if (lines_reg == 16'd0)
                begin
                    cmd.term   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_LINE;
            end
            PH_PIXEL:
            begin
                push_c      = 1'b1;
                cmd.op      = OP_PIXEL;
                cmd.two     = two;
                cmd.idx_a   = two ? {4'd0, b[7:4]} : b;
                cmd.idx_b   = {4'd0, b[3:0]};
                cmd.ok_a    = (cmd.idx_a < cc_reg) && ({1'b0, cmd.idx_a} < DEPTH_W);
                cmd.ok_b    = (cmd.idx_b < cc_reg) && ({1'b0, cmd.idx_b} < DEPTH_W);
                pixels_next = two ? (pixels_reg - 8'd2) : 8'd0;
                if (pixels_next == 8'd0)
                begin
                    if (spans_reg != 8'd0)
                        phase_next = PH_JUMP;
                    else if (lines_reg == 16'd0)
                    begin
                        cmd.term   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LINE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            cnt_reg    <= '0;
            cc_reg     <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            size_reg   <= '0;
            asm_reg    <= '0;
            lines_reg  <= '0;
            spans_reg  <= '0;
            pixels_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            cc_reg     <= cc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            size_reg   <= size_next;
            asm_reg    <= asm_next;
            lines_reg  <= lines_next;
            spans_reg  <= spans_next;
            pixels_reg <= pixels_next;
        end
    end

endmodule

// ===== design/nsse_cmd_fifo.sv =====
// Short command queue between the parser and the word generator.
module nsse_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nsse_pkg::cmd_t push_cmd,
    input  logic           pop,
    output nsse_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import nsse_pkg::*;

    cmd_t               slots_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== design/nsse_back.sv =====
// Word generator: expands queued commands into output words and owns the palette.
module nsse_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  nsse_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    nsse_out_if.source     out_ch
);
    import nsse_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [31:0] palette_mem [PALETTE_DEPTH];

    logic [1:0]  step_reg;
    logic [1:0]  n_main;
    logic [2:0]  total;
    logic        at_last;
    logic        is_term;
    logic        emit;
    logic        pal_rd;
    logic        sel_ok;
    logic [7:0]  sel_idx;
    logic [31:0] lit;
    logic        adv;
    logic        mem_we;

    logic        out_valid_reg;
    logic [31:0] lit_reg;
    logic [31:0] rd_reg;
    logic        sel_pal_reg;
    logic        last_reg;
    logic        bad_reg;

    always_comb
    begin
        unique case (head.op)
            OP_HEADER:  n_main = 2'd3;
            OP_BYTE:    n_main = 2'd1;
            OP_PIXEL:   n_main = head.two ? 2'd2 : 2'd1;
            OP_PALETTE: n_main = 2'd0;
            default:    n_main = 2'd0;
        endcase
        total   = (head.op == OP_PALETTE) ? 3'd1 : ({1'b0, n_main} + {2'd0, head.term});
        at_last = (({1'b0, step_reg} + 3'd1) == total);
        is_term = (step_reg >= n_main);
        emit    = !((head.op == OP_PALETTE) && !head.term);
        pal_rd  = (head.op == OP_PIXEL) && !is_term;
        sel_ok  = step_reg[0] ? head.ok_b : head.ok_a;
        sel_idx = step_reg[0] ? head.idx_b : head.idx_a;

        lit = '0;
        if (is_term)
            lit = TERMINATOR_WORD;
        else if (head.op == OP_HEADER)
        begin
            case (step_reg)
                2'd0:    lit = SIGNATURE_WORD;
                2'd1:    lit = head.word_a;
                default: lit = head.word_b;
            endcase
        end
        else if (head.op == OP_BYTE)
            lit = head.word_a;
    end

    assign adv    = head_valid && (!out_valid_reg || out_ch.ready);
    assign pop    = adv && at_last;
    assign mem_we = adv && (head.op == OP_PALETTE) && head.wr && (step_reg == 2'd0);

    // Writes and reads follow command order, so a colour is stored before any later read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            palette_mem[head.idx_a[AW-1:0]] <= head.word_a;
        if (adv && pal_rd && sel_ok)
            rd_reg <= palette_mem[sel_idx[AW-1:0]];
        if (adv)
        begin
            lit_reg     <= lit;
            sel_pal_reg <= pal_rd && sel_ok;
            last_reg    <= is_term;
            bad_reg     <= pal_rd && !sel_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                step_reg      <= at_last ? 2'd0 : (step_reg + 2'd1);
                out_valid_reg <= emit;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_word  = sel_pal_reg ? rd_reg : lit_reg;
    assign out_ch.last_word = last_reg;
    assign out_ch.bad_index = bad_reg;

endmodule

// ===== design/nibble_span_sprite_expander_core.sv =====
// Top level of the nibble span sprite expander: parser, command queue, word generator.
//
// The in_ch channel takes one byte of a packed 4-bit sprite object per beat; first_byte
// marks header byte 0 and restarts the parser. The out_ch channel delivers the expanded
// 32-bit words: signature, object size, width and height, every span count, jump and
// size byte, one palette colour per pixel, and a terminator beat with last_word set.
// A pixel index at or above the colour count or the palette depth yields a zero word with bad_index set.
// Each accepted byte's command is written into the command queue, and the word generator
// then registers its word into the output stage. Throughput: one word per cycle while
// out_ch is ready, so bytes that yield one word stream at one per cycle, a pixel byte
// holding two indices yields two words, and the last header byte three or four.
// The palette memory has one port, used by one write or one read per cycle.
// A four-entry command queue lets the parser keep taking bytes while out_ch stalls; when
// it fills, in_ch.ready drops until the receiver takes words again.
// After reset the parser waits for header byte 0, the queue and output stage are empty,
// and palette entries hold unknown data until the palette section of an object writes
// them. Bytes after the terminator are dropped until the next first_byte.
module nibble_span_sprite_expander_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    nsse_in_if.sink     in_ch,
    nsse_out_if.source  out_ch
);
    import nsse_pkg::*;

    // Commands leave the parser and wait in the queue until the word generator runs them.
    cmd_t cmd;
    cmd_t head;
    logic cmd_push;
    logic fifo_full;
    logic fifo_empty;
    logic pop;

    nsse_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    nsse_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // The generator sees a head command whenever the queue holds one.
    nsse_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!fifo_empty),
        .pop        (pop),
        .out_ch     (out_ch)
    );

`ifndef SYNTHESIS
    // The parser never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !fifo_full)
        else $error("command pushed into a full queue");

    // An out-of-range index always shows as a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.bad_index) |-> (out_ch.out_word == 32'd0))
        else $error("bad index beat carries a nonzero word");

    // The closing beat carries the terminator and never a pixel flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last_word) |->
            ((out_ch.out_word == TERMINATOR_WORD) && !out_ch.bad_index))
        else $error("last beat is not a clean terminator");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !fifo_empty)
        else $error("pop from an empty command queue");
`endif

endmodule
